// File: hdl/sbpr_pkg.sv
// Shared types, constants and the scale lookup for the sensor bus poll responder.
package sbpr_pkg;

   // Largest slot count the slot index field can address
   localparam int SLOT_MAX = 16;
   localparam int SLOT_COUNT_DEFAULT = 16;

   // Formatting constants
   localparam logic [13:0] SAT_LIMIT      = 14'd16383;
   localparam logic [7:0]  ROUND_Q8       = 8'd128;        // half of one Q8 unit
   localparam logic [10:0] ROUND_DIV_TEN  = 11'd1280;      // half of 2560
   localparam logic [32:0] DIV_TEN_OVER   = 33'd41943040;  // 16384 * 2560
   localparam logic [17:0] RECIP_TEN      = 18'd209716;    // ceil(2^21 / 10)
   localparam int          RECIP_SHIFT    = 21;

   typedef enum logic [1:0] {
      SCALE_PLAIN   = 2'd0,
      SCALE_TIMES10 = 2'd1,
      SCALE_DIV10   = 2'd2
   } scale_type;

   typedef enum logic [1:0] {
      BYTE_ID   = 2'd0,
      BYTE_LOW  = 2'd1,
      BYTE_HIGH = 2'd2
   } byte_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic         capture;   // latch slot value, type and address of an accepted poll
      logic         write;     // store the sample of an accepted update
      logic         calc;      // scale, round and flag saturation
      logic         fmt;       // clamp and build the reply word
      byte_sel_type byte_sel;  // which reply byte drives the output
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic hit;  // poll address names a filled slot
   } status_type;

   function automatic scale_type scale_of(input logic [3:0] code);
      scale_type s;
      case (code)
         4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd13: s = SCALE_TIMES10;
         4'd5:                                    s = SCALE_DIV10;
         default:                                 s = SCALE_PLAIN;
      endcase
      return s;
   endfunction

endpackage

// File: hdl/sbpr_ctrl.sv
// Sequencer for the sensor bus poll responder: accept, format steps, reply beats.
module sbpr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_operation,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_last_byte,
   input  sbpr_pkg::status_type status,
   output sbpr_pkg::cmd_type    cmd
);
   import sbpr_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CALC  = 6'b000010,
      ST_FMT   = 6'b000100,
      ST_BYTE0 = 6'b001000,
      ST_BYTE1 = 6'b010000,
      ST_BYTE2 = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready     = (state_ff == ST_IDLE);
   assign accept        = req_valid && req_ready;
   assign rsp_valid     = (state_ff == ST_BYTE0) || (state_ff == ST_BYTE1) ||
                          (state_ff == ST_BYTE2);
   assign rsp_last_byte = (state_ff == ST_BYTE2);

   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.write    = 1'b0;
      cmd.calc     = 1'b0;
      cmd.fmt      = 1'b0;
      cmd.byte_sel = BYTE_ID;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_operation) begin
                  cmd.write = 1'b1;
               end else if (status.hit) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_FMT;
         end
         ST_FMT: begin
            cmd.fmt  = 1'b1;
            state_in = ST_BYTE0;
         end
         ST_BYTE0: begin
            cmd.byte_sel = BYTE_ID;
            if (rsp_ready) state_in = ST_BYTE1;
         end
         ST_BYTE1: begin
            cmd.byte_sel = BYTE_LOW;
            if (rsp_ready) state_in = ST_BYTE2;
         end
         ST_BYTE2: begin
            cmd.byte_sel = BYTE_HIGH;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/sbpr_datapath.sv
// Slot store, type register and measurement formatter of the poll responder.
module sbpr_datapath #(
   parameter int SLOT_COUNT = sbpr_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [63:0]         csr_write_data,
   input  logic [7:0]          req_poll_address,
   input  logic [3:0]          req_slot_index,
   input  logic signed [31:0]  req_sample_value,
   input  sbpr_pkg::cmd_type    cmd,
   output sbpr_pkg::status_type status,
   output logic [7:0]          rsp_out_byte
);
   import sbpr_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [8:0] SLOT_LIMIT = 9'(SLOT_COUNT);

   logic [63:0]        slot_types_ff;
   logic signed [31:0] slot_values_ff [SLOT_COUNT];

   logic [3:0]         addr_ff;
   logic [3:0]         code_ff;
   logic signed [31:0] value_ff;
   scale_type          scale_ff;

   logic               neg_ff;
   logic               over_ff;
   logic               div_ff;
   logic [13:0]        qmag_ff;
   logic [35:0]        prod_ff, prod_in;

   logic [15:0]        word_ff, word_in;

   logic [3:0]  poll_code;
   logic        poll_in_range;
   logic        update_in_range;

   logic [31:0] mag;
   logic [35:0] times10_sum;
   logic [32:0] plain_sum;
   logic [32:0] div_sum;
   logic [27:0] q_sel;
   logic        over_in;
   logic [17:0] div_t;
   logic [13:0] mag_final;
   logic [15:0] word_pos;

   // Slot lookup for an offered poll
   assign poll_in_range   = {1'b0, req_poll_address} < SLOT_LIMIT;
   assign poll_code       = slot_types_ff[{req_poll_address[3:0], 2'b00} +: 4];
   assign status.hit      = poll_in_range && (poll_code != 4'd0);
   assign update_in_range = {5'd0, req_slot_index} < SLOT_LIMIT;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_types_ff <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_values_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) slot_types_ff <= csr_write_data;
         if (cmd.write && update_in_range) begin
            slot_values_ff[req_slot_index[IDX_W-1:0]] <= req_sample_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff  <= req_poll_address[3:0];
         code_ff  <= poll_code;
         scale_ff <= scale_of(poll_code);
         value_ff <= slot_values_ff[req_poll_address[IDX_W-1:0]];
      end
   end

   // Scale and round the magnitude; the divide by 2560 goes through a reciprocal product
   always_comb begin
      mag         = value_ff[31] ? (32'd0 - value_ff) : value_ff;
      times10_sum = 36'({mag, 3'b000}) + 36'({mag, 1'b0}) + 36'(ROUND_Q8);
      plain_sum   = 33'(mag) + 33'(ROUND_Q8);
      div_sum     = 33'(mag) + 33'(ROUND_DIV_TEN);
      div_t       = div_sum[25:8];
      prod_in     = 36'(div_t) * 36'(RECIP_TEN);
      q_sel       = (scale_ff == SCALE_TIMES10) ? times10_sum[35:8]
                                                : 28'(plain_sum[32:8]);
      if (scale_ff == SCALE_DIV10) begin
         over_in = div_sum >= DIV_TEN_OVER;
      end else begin
         over_in = q_sel > 28'(SAT_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         neg_ff  <= value_ff[31];
         over_ff <= over_in;
         div_ff  <= (scale_ff == SCALE_DIV10);
         qmag_ff <= q_sel[13:0];
         prod_ff <= prod_in;
      end
   end

   // Clamp, shift left one and apply the sign
   always_comb begin
      if (over_ff) begin
         mag_final = SAT_LIMIT;
      end else if (div_ff) begin
         mag_final = prod_ff[RECIP_SHIFT+13:RECIP_SHIFT];
      end else begin
         mag_final = qmag_ff;
      end
      word_pos = {1'b0, mag_final, 1'b0};
      word_in  = neg_ff ? (16'd0 - word_pos) : word_pos;
   end

   always_ff @(posedge clock) begin
      if (cmd.fmt) word_ff <= word_in;
   end

   always_comb begin
      case (cmd.byte_sel)
         BYTE_ID:   rsp_out_byte = {addr_ff, code_ff};
         BYTE_LOW:  rsp_out_byte = word_ff[7:0];
         BYTE_HIGH: rsp_out_byte = word_ff[15:8];
         default:   rsp_out_byte = {addr_ff, code_ff};
      endcase
   end

endmodule

// File: hdl/sensor_bus_poll_responder_core.sv
// Top level of the sensor bus poll responder: sequencer plus slot datapath.
//
// Keeps SLOT_COUNT sensor slots. csr_write_data holds sixteen 4-bit type codes
// (slot i in bits 4i+3..4i, code 0 marks an empty slot) and is taken on any
// clock with csr_write_enable high; write it only while the block is idle.
// An update beat (req_operation = 1) stores req_sample_value, signed Q8, into
// slot req_slot_index; an index beyond the last slot is dropped. A poll beat
// (req_operation = 0) whose address names a filled slot produces three reply
// beats: the id byte (address << 4 | type), then the low and high byte of the
// formatted word, the third beat flagged by rsp_last_byte. Polls of empty or
// out-of-range slots produce nothing. Formatting scales the value by ten for
// types 1-4, 6, 7 and 13, divides it by ten for type 5 and leaves it otherwise,
// rounds half away from zero, clamps to +/-16383 and shifts left one in 16-bit
// two's complement. A served poll passes through the accept, a formatting step
// that scales and rounds (with the reciprocal multiply for the divide by ten),
// a step that clamps and applies the sign, and three reply beats; req_ready is
// high only between items, and a reply beat is held while rsp_ready is low.
// Reset clears all slot values and type codes.
module sensor_bus_poll_responder_core #(
   parameter int SLOT_COUNT = sbpr_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_write_enable,
   input  logic [63:0]        csr_write_data,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [7:0]         req_poll_address,
   input  logic [3:0]         req_slot_index,
   input  logic signed [31:0] req_sample_value,
   // reply channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_byte
);
   import sbpr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer: owns both handshakes and steps the datapath
   sbpr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_last_byte (rsp_last_byte),
      .status        (status),
      .cmd           (cmd)
   );

   // Datapath: type register, slot values, formatter and reply byte select
   sbpr_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_poll_address (req_poll_address),
      .req_slot_index   (req_slot_index),
      .req_sample_value (req_sample_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_out_byte     (rsp_out_byte)
   );

`ifndef SYNTHESIS
   // Never take a request while a reply is being offered
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("request taken during a reply");

   // After the final reply beat the block goes straight back to waiting for requests
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_byte) |=> (req_ready && !rsp_valid))
      else $error("reply did not end after the last beat");

   // Polls of addresses beyond the slot range produce no reply
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_operation &&
       ({1'b0, req_poll_address} >= 9'(SLOT_COUNT))) |=> (req_ready && !rsp_valid))
      else $error("out-of-range poll produced a reply");

   // Updates produce no reply
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_operation) |=> !rsp_valid)
      else $error("update produced a reply");
`endif

endmodule
